// ===== rtl/sorted_top_k_insert_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted top-k insertion list.
// Each macro is active in simulation and expands to nothing in synthesis.
// The macros expect clk_i and rst_ni in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef SORTED_TOP_K_INSERT_TOP_ASSERT_SVH
`define SORTED_TOP_K_INSERT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define STKI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checks that a condition never occurs outside reset.
`define STKI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define STKI_ASSERT(lbl, prop, msg)
`define STKI_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/stki_pkg.sv =====
// ---------------------------------------------------------------------------
// stki_pkg
// Types and constants shared by the sorted top-k insertion list modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stki_pkg;

  // Fixed field widths of the request and result.
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned RANK_W  = 3;
  localparam int unsigned COUNT_W = 4;

  // Default number of list entries.
  localparam int unsigned LIST_DEPTH_DEF = 8;

  // Request commands.
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  // Data and status passed from one cell to the next.
  typedef struct packed {
    logic                      place;  // new score belongs here or above
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } cell_link_t;

  // One result.
  typedef struct packed {
    logic                      inserted;
    logic [RANK_W-1:0]         insert_rank;
    logic [COUNT_W-1:0]        entry_count;
    logic                      read_valid;
    logic signed [SCORE_W-1:0] read_score;
    logic [TAG_W-1:0]          read_tag;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/stki_cell.sv =====
// ---------------------------------------------------------------------------
// stki_cell
// One list slot: compares the new score with its own and either keeps its
// entry, takes the new entry, or takes the entry of the cell above it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stki_cell
  import stki_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire logic signed [SCORE_W-1:0] new_score_i,
  input  wire logic [TAG_W-1:0]          new_tag_i,
  input  wire cell_link_t                prev_i,
  output cell_link_t                     link_o
);

  logic                      valid_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [TAG_W-1:0]          tag_q;
  logic                      place;

  // An empty slot or a strictly lower stored score gives way to the new entry.
  assign place = !valid_q || (new_score_i > score_q);

  // Valid flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      if (prev_i.place) begin
        valid_q <= prev_i.valid;
      end else if (place) begin
        valid_q <= 1'b1;
      end
    end
  end

  // Entry payload: shift down from above, or take the new entry at the insert position.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      if (prev_i.place) begin
        score_q <= prev_i.score;
        tag_q   <= prev_i.tag;
      end else if (place) begin
        score_q <= new_score_i;
        tag_q   <= new_tag_i;
      end
    end
  end

  assign link_o = '{place: place, valid: valid_q, score: score_q, tag: tag_q};

endmodule

`default_nettype wire

// ===== rtl/stki_out_buf.sv =====
// ---------------------------------------------------------------------------
// stki_out_buf
// Two-entry result buffer that decouples the list from the output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stki_out_buf
  import stki_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    stall_i,
  output result_t      data_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = slot_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i && pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_top_k_insert_top.sv =====
// Results wait in the result buffer and are offered in request order.
// Throughput: one request per cycle while the result buffer has room; each
// insert updates every cell of the compare-and-shift chain in that single
// cycle, and a two-entry result buffer absorbs output stalls.
// Reset: all cells are marked empty and the entry count is zero; the buffer is
// emptied. Stored scores and tags are not cleared.
// ---------------------------------------------------------------------------
// sorted_top_k_insert_top
// Bounded list of (score, tag) entries kept in descending score order, built
// as a chain of slot cells with a read port over at most the first eight positions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_top_k_insert_top_assert.svh"

module sorted_top_k_insert_top
  import stki_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Request channel.
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      command_i,
  input  wire logic signed [SCORE_W-1:0] new_score_i,
  input  wire logic [TAG_W-1:0]          entry_tag_i,
  input  wire logic                      name_present_i,
  input  wire logic [IDX_W-1:0]          read_index_i,
  // Result channel.
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           inserted_o,
  output logic [RANK_W-1:0]              insert_rank_o,
  output logic [COUNT_W-1:0]             entry_count_o,
  output logic                           read_valid_o,
  output logic signed [SCORE_W-1:0]      read_score_o,
  output logic [TAG_W-1:0]               read_tag_o
);

  localparam int unsigned POS_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned RD_N  = (LIST_DEPTH < (1 << IDX_W)) ? LIST_DEPTH
                                                               : (1 << IDX_W);

  cell_link_t                link      [LIST_DEPTH];
  cell_link_t                prev_link [LIST_DEPTH];
  logic                      req_acc;
  logic                      is_insert;
  logic                      ins_req;
  logic                      ins_ok;
  logic                      full;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          count_d;
  logic [POS_W-1:0]          pos;
  logic [POS_W+RANK_W-1:0]   pos_ext;
  logic [CNT_W+COUNT_W-1:0]  count_ext;
  logic                      rd_hit;
  logic signed [SCORE_W-1:0] rd_score;
  logic [TAG_W-1:0]          rd_tag;
  logic                      buf_full;
  result_t                   res;
  result_t                   res_out;

  // Request handshake.
  assign in_stall_o = buf_full;
  assign req_acc    = in_valid_i && !in_stall_o;
  assign is_insert  = (command_i == CMD_INSERT);
  assign ins_req    = req_acc && is_insert && name_present_i;

  // The place flags are monotone along the chain, so the last one tells
  // whether the new entry lands anywhere.
  assign full   = link[LIST_DEPTH-1].valid;
  assign ins_ok = link[LIST_DEPTH-1].place;

  // Cell chain; the head cell sees a neighbor that never gives way.
  assign prev_link[0] = '{place: 1'b0, valid: 1'b0, score: '0, tag: '0};

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_prev
      assign prev_link[i] = link[i-1];
    end
    stki_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (ins_req),
      .new_score_i (new_score_i),
      .new_tag_i   (entry_tag_i),
      .prev_i      (prev_link[i]),
      .link_o      (link[i])
    );
  end

  // Insert position: the one cell that gives way while its neighbor does not.
  always_comb begin
    pos = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (link[i].place && !prev_link[i].place) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  // Entry count grows on an insert until the list is full.
  assign count_d = count_q + CNT_W'(ins_req && ins_ok && !full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Read port over the positions the index can reach.
  assign rd_hit = (CMP_W'(read_index_i) < CMP_W'(count_q));

  always_comb begin
    rd_score = '0;
    rd_tag   = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (read_index_i == IDX_W'(k)) begin
        rd_score = link[k].score;
        rd_tag   = link[k].tag;
      end
    end
  end

  // Result assembly; fields of the other command read as zero.
  assign pos_ext   = {{RANK_W{1'b0}}, pos};
  assign count_ext = {{COUNT_W{1'b0}}, count_d};

  always_comb begin
    res             = '0;
    res.entry_count = count_ext[COUNT_W-1:0];
    if (is_insert) begin
      if (name_present_i && ins_ok) begin
        res.inserted    = 1'b1;
        res.insert_rank = pos_ext[RANK_W-1:0];
      end
    end else if (rd_hit) begin
      res.read_valid = 1'b1;
      res.read_score = rd_score;
      res.read_tag   = rd_tag;
    end
  end

  // Result buffer.
  stki_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_acc),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign inserted_o    = res_out.inserted;
  assign insert_rank_o = res_out.insert_rank;
  assign entry_count_o = res_out.entry_count;
  assign read_valid_o  = res_out.read_valid;
  assign read_score_o  = res_out.read_score;
  assign read_tag_o    = res_out.read_tag;

  // The head cell is occupied exactly when the list is not empty.
  `STKI_ASSERT(a_head_matches_count, link[0].valid == (count_q != '0), "head valid vs count")
  // A stalled request side means the buffer holds results to hand out.
  `STKI_ASSERT(a_stall_has_result, in_stall_o |-> out_valid_o, "stall without result")
  // An entry that ranks last in a full list leaves the count alone.
  `STKI_ASSERT(a_full_drop_keeps_count, (ins_req && full && !ins_ok) |=> $stable(count_q), "drop changed count")
  // An accepted insert into a list with room grows it by one.
  `STKI_ASSERT(a_insert_grows_count, (ins_req && ins_ok && !full) |=> (count_q == CNT_W'($past(count_q) + 1'b1)), "count did not grow")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: sorted top-k insertion list testbench
// Drives insert and read requests into the list and holds its own model of
// the ranking board. Each result is checked in order against the model, or for
// a typed row against its own expectation. A short directed table comes first,
// then random requests with ties and near-ties, random idling on both channels
// and one long output hold-off that backs the list up into its request channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import stki_pkg::*;

  localparam int unsigned DEPTH           = LIST_DEPTH_DEF;
  localparam int unsigned RANDOM_REQUESTS = 1600;
  localparam int unsigned HOLD_OFF_CYCLES = 64;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  // One request as offered on the input channel.
  typedef struct packed {
    cmd_e               cmd;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               named;
    logic [IDX_W-1:0]   idx;
  } request_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct packed {
    request_t req;
    logic     typed;
    result_t  want;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      command_i;
  logic signed [SCORE_W-1:0] new_score_i;
  logic [TAG_W-1:0]          entry_tag_i;
  logic                      name_present_i;
  logic [IDX_W-1:0]          read_index_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      inserted_o;
  logic [RANK_W-1:0]         insert_rank_o;
  logic [COUNT_W-1:0]        entry_count_o;
  logic                      read_valid_o;
  logic signed [SCORE_W-1:0] read_score_o;
  logic [TAG_W-1:0]          read_tag_o;

  // Model of the ranking board.
  logic signed [SCORE_W-1:0] board_score [DEPTH];
  logic [TAG_W-1:0]          board_tag [DEPTH];
  int unsigned               board_count = 0;

  result_t     pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned idle_pct = 28;
  bit          hold_off_req = 1'b0;
  int unsigned fault_count = 0;
  int unsigned placed_count = 0;
  int unsigned dropped_count = 0;
  int unsigned ignored_count = 0;
  int unsigned read_hits = 0;
  int unsigned read_misses = 0;
  int unsigned held_cycles = 0;

  sorted_top_k_insert_top #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .new_score_i    (new_score_i),
    .entry_tag_i    (entry_tag_i),
    .name_present_i (name_present_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inserted_o     (inserted_o),
    .insert_rank_o  (insert_rank_o),
    .entry_count_o  (entry_count_o),
    .read_valid_o   (read_valid_o),
    .read_score_o   (read_score_o),
    .read_tag_o     (read_tag_o)
  );

  // Free-running clock, 4 ns period.
  always #2 clk_i = ~clk_i;

  // Applies one request to the board and returns the result it should give.
  function automatic result_t apply_to_board(input request_t r);
    result_t     res;
    int unsigned pos;
    int unsigned i;
    res = '0;
    if (r.cmd == CMD_INSERT) begin
      if (r.named) begin
        pos = board_count;
        // The new entry goes ahead of the first strictly lower score.
        for (i = 0; i < board_count; i++) begin
          if ($signed(r.score) > board_score[i]) begin
            pos = i;
            break;
          end
        end
        if (pos < DEPTH) begin
          if (board_count < DEPTH) board_count++;
          for (i = board_count - 1; i > pos; i--) begin
            board_score[i] = board_score[i-1];
            board_tag[i]   = board_tag[i-1];
          end
          board_score[pos] = r.score;
          board_tag[pos]   = r.tag;
          res.inserted     = 1'b1;
          res.insert_rank  = pos[RANK_W-1:0];
        end
      end
    end else if (r.idx < board_count) begin
      res.read_valid = 1'b1;
      res.read_score = board_score[r.idx];
      res.read_tag   = board_tag[r.idx];
    end
    res.entry_count = board_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic request_t mk_request(input cmd_e c, input logic [SCORE_W-1:0] s,
                                          input logic [TAG_W-1:0] t, input logic n,
                                          input logic [IDX_W-1:0] x);
    request_t r;
    r.cmd   = c;
    r.score = s;
    r.tag   = t;
    r.named = n;
    r.idx   = x;
    return r;
  endfunction

  function automatic result_t mk_result(input logic ins, input logic [RANK_W-1:0] rank,
                                        input logic [COUNT_W-1:0] cnt, input logic rv,
                                        input logic [SCORE_W-1:0] rs,
                                        input logic [TAG_W-1:0] rt);
    result_t res;
    res.inserted    = ins;
    res.insert_rank = rank;
    res.entry_count = cnt;
    res.read_valid  = rv;
    res.read_score  = rs;
    res.read_tag    = rt;
    return res;
  endfunction

  task automatic add_row(input request_t r, input logic typed, input result_t w);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = w;
    directed_rows.push_back(row);
  endtask

  // Random request, biased toward ties and near-ties with stored scores so
  // that a full board keeps taking entries at every rank.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned slot;
    r.cmd   = ($urandom_range(99) < 30) ? CMD_READ : CMD_INSERT;
    r.tag   = $urandom;
    r.named = ($urandom_range(99) < 92);
    r.idx   = IDX_W'($urandom_range(DEPTH - 1));
    pick    = $urandom_range(99);
    slot    = (board_count == 0) ? 0 : $urandom_range(board_count - 1);
    if (board_count == 0 || pick < 20) begin
      r.score = $urandom;
    end else if (pick < 50) begin
      r.score = board_score[slot];
    end else if (pick < 85) begin
      r.score = board_score[slot] + $urandom_range(6) - 32'd3;
    end else if (pick < 87) begin
      r.score = SCORE_MIN;
    end else begin
      r.score = $urandom_range(40) - 32'd20;
    end
    return r;
  endfunction

  // Offers one request, holds it through stalls and records its expectation
  // once it is taken. Starts and ends at a falling edge.
  task automatic send_request(input request_t r, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    command_i      = r.cmd;
    new_score_i    = r.score;
    entry_tag_i    = r.tag;
    name_present_i = r.named;
    read_index_i   = r.idx;
    @(posedge clk_i);
    while (in_stall_o) begin
      held_cycles++;
      @(posedge clk_i);
    end
    predicted = apply_to_board(r);
    pending_results.push_back(typed ? want : predicted);
    if (r.cmd == CMD_READ) begin
      if (predicted.read_valid) read_hits++;
      else read_misses++;
    end else if (!r.named) begin
      ignored_count++;
    end else if (predicted.inserted) begin
      placed_count++;
    end else begin
      dropped_count++;
    end
    @(negedge clk_i);
  endtask

  // Result channel: random stalls, plus one long hold-off on request.
  initial begin : result_stall_driver
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      out_stall_i = ($urandom_range(99) < idle_pct);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = mk_result(inserted_o, insert_rank_o, entry_count_o, read_valid_o,
                      read_score_o, read_tag_o);
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: result with no request outstanding", $time);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch", $time);
            $display("  want ins=%0d rank=%0d count=%0d rv=%0d score=%0d tag=%h",
                     want.inserted, want.insert_rank, want.entry_count,
                     want.read_valid, $signed(want.read_score), want.read_tag);
            $display("  got  ins=%0d rank=%0d count=%0d rv=%0d score=%0d tag=%h",
                     got.inserted, got.insert_rank, got.entry_count,
                     got.read_valid, $signed(got.read_score), got.read_tag);
          end
        end
      end
    end
  end

  // Hard stop in case the list hangs.
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    request_t    r;
    int unsigned useful;
    in_valid_i     = 1'b0;
    command_i      = CMD_INSERT;
    new_score_i    = '0;
    entry_tag_i    = '0;
    name_present_i = 1'b0;
    read_index_i   = '0;

    // Directed table: empty board, extremes, ties, a full board and reads.
    add_row(mk_request(CMD_READ, 0, 0, 1'b1, 3'd0), 1'b1, mk_result(0, 0, 0, 0, 0, 0));
    add_row(mk_request(CMD_READ, 0, 0, 1'b1, 3'd7), 1'b1, mk_result(0, 0, 0, 0, 0, 0));
    add_row(mk_request(CMD_INSERT, 5, 32'h1234, 1'b0, 3'd0), 1'b1,
            mk_result(0, 0, 0, 0, 0, 0));
    add_row(mk_request(CMD_INSERT, SCORE_MAX, 32'hffff_ffff, 1'b1, 3'd0), 1'b1,
            mk_result(1, 0, 1, 0, 0, 0));
    add_row(mk_request(CMD_INSERT, SCORE_MIN, 32'h0, 1'b1, 3'd0), 1'b1,
            mk_result(1, 1, 2, 0, 0, 0));
    add_row(mk_request(CMD_READ, 0, 0, 1'b0, 3'd0), 1'b1,
            mk_result(0, 0, 2, 1, SCORE_MAX, 32'hffff_ffff));
    add_row(mk_request(CMD_READ, 0, 0, 1'b0, 3'd1), 1'b1,
            mk_result(0, 0, 2, 1, SCORE_MIN, 32'h0));
    add_row(mk_request(CMD_READ, 0, 0, 1'b1, 3'd2), 1'b1, mk_result(0, 0, 2, 0, 0, 0));
    add_row(mk_request(CMD_INSERT, 0, 32'ha5a5_a5a5, 1'b1, 3'd0), 1'b1,
            mk_result(1, 1, 3, 0, 0, 0));
    // A tie goes behind the older entry.
    add_row(mk_request(CMD_INSERT, 0, 32'h5a5a_5a5a, 1'b1, 3'd0), 1'b1,
            mk_result(1, 2, 4, 0, 0, 0));
    add_row(mk_request(CMD_INSERT, SCORE_MAX, 32'h0000_ffff, 1'b1, 3'd0), 1'b1,
            mk_result(1, 1, 5, 0, 0, 0));
    add_row(mk_request(CMD_INSERT, -1, 32'h1, 1'b1, 3'd0), 1'b0, '0);
    add_row(mk_request(CMD_INSERT, 100, 32'hffff_0000, 1'b1, 3'd0), 1'b0, '0);
    add_row(mk_request(CMD_INSERT, -100, 32'h1357_9bdf, 1'b1, 3'd0), 1'b0, '0);
    // Full board and a score that beats nothing: the entry is dropped.
    add_row(mk_request(CMD_INSERT, SCORE_MIN, 32'hdead_beef, 1'b1, 3'd0), 1'b1,
            mk_result(0, 0, 8, 0, 0, 0));
    add_row(mk_request(CMD_INSERT, SCORE_MAX, 32'h0bad_cafe, 1'b0, 3'd0), 1'b1,
            mk_result(0, 0, 8, 0, 0, 0));
    // Full board: the last entry falls off.
    add_row(mk_request(CMD_INSERT, 1, 32'h2468_ace0, 1'b1, 3'd0), 1'b0, '0);
    for (int i = 0; i < DEPTH; i++)
      add_row(mk_request(CMD_READ, 0, 0, 1'b1, i[IDX_W-1:0]), 1'b0, '0);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // Random requests; a quiet stretch in the middle carries the hold-off.
    useful = 0;
    while (useful < RANDOM_REQUESTS) begin
      if (useful == 500) begin
        idle_pct     = 0;
        hold_off_req = 1'b1;
      end else if (useful == 800) begin
        idle_pct = 28;
      end
      r = random_request();
      send_request(r, 1'b0, '0);
      if (!(r.cmd == CMD_INSERT && !r.named)) useful++;
    end
    in_valid_i = 1'b0;

    // Drain, then keep watching for anything stray.
    idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Inserts: %0d placed, %0d dropped on a full board, %0d without a name.",
             placed_count, dropped_count, ignored_count);
    $display("Reads: %0d in range, %0d out of range; request channel held %0d cycles.",
             read_hits, read_misses, held_cycles);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
